// ===== hw/rtl/dtrm_pkg.sv =====
// Shared types, widths and a helper function for the double tree rank map.
package dtrm_pkg;

  // Fixed field widths.
  localparam int POS_W     = 10;
  localparam int PATH_W    = POS_W + 1;
  localparam int RANK_W    = 10;
  localparam int NC_W      = 11;
  localparam int ROOT_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = NC_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_A     = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [NC_W-1:0]   NODE_COUNT_RST = 11'd8;
  localparam logic [ROOT_W-1:0] ROOT_A_RST     = 10'd0;

  // Remainder unit: one step per bit of root_a, then one step for tree B's root.
  localparam int MOD_STEPS = ROOT_W;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS + 2);
  localparam logic [MOD_CNT_W-1:0] MOD_LAST_DIV = MOD_CNT_W'(MOD_STEPS);
  localparam logic [MOD_CNT_W-1:0] MOD_DONE     = MOD_CNT_W'(MOD_STEPS + 1);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DONE
  } dtrm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic finish;
  } dtrm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic mod_done;
  } dtrm_sts_t;

  // Index of the highest set bit; zero for a zero input.
  function automatic logic [4:0] msb_idx(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/dtrm_in_if.sv =====
// Request channel carrying one heap position.
interface dtrm_in_if;
  import dtrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

// ===== hw/rtl/dtrm_out_if.sv =====
// Result channel carrying the ranks of one position in both trees.
interface dtrm_out_if;
  import dtrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank_a;
  logic [RANK_W-1:0] rank_b;
  logic              in_range;
  logic              config_error;

  modport source (output valid, output rank_a, output rank_b, output in_range,
                  output config_error, input ready);
  modport sink   (input valid, input rank_a, input rank_b, input in_range,
                  input config_error, output ready);
endinterface

// ===== hw/rtl/dtrm_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
module dtrm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output dtrm_pkg::dtrm_cmd_t cmd,
  input  dtrm_pkg::dtrm_sts_t sts
);
  import dtrm_pkg::*;

  dtrm_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && in_ready;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (sts.walk_done && sts.mod_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // The result register is free once its previous result is taken.
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The walk phase is left only when both units have finished.
  a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) && !(sts.walk_done && sts.mod_done) |=> (state_r == ST_RUN))
    else $error("left the walk phase before both units finished");

  // A finished result is always presented in the following cycle.
  a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result loaded but not presented");

  // A pending result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid_r || out_ready)
    else $error("result register overwritten while held");

endmodule

// ===== hw/rtl/dtrm_dpath.sv =====
// Datapath: configuration registers, in-order walk, remainder unit, result registers.
module dtrm_dpath #(
  parameter int MAX_NODES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dtrm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [dtrm_pkg::CFG_W-1:0]     cfg_data,
  input  logic [dtrm_pkg::POS_W-1:0]     position,
  input  dtrm_pkg::dtrm_cmd_t           cmd,
  output dtrm_pkg::dtrm_sts_t           sts,
  output logic [dtrm_pkg::RANK_W-1:0]    rank_a,
  output logic [dtrm_pkg::RANK_W-1:0]    rank_b,
  output logic                          in_range,
  output logic                          config_error
);
  import dtrm_pkg::*;

  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int WW = NW + 1;
  localparam int CW = (NW > NC_W) ? NW : NC_W;

  // Configuration registers.
  logic [NC_W-1:0]   node_count_r;
  logic [ROOT_W-1:0] root_a_r;

  // Per-request registers.
  logic [POS_W-1:0]     pos_r;
  logic [NW-1:0]        n_r;
  logic [ROOT_W-1:0]    root_r;
  logic                 inr_r;
  logic                 err_r;

  // Walk registers.
  logic [PATH_W-1:0]    path_r;
  logic [PATH_W-1:0]    bitsel_r;
  logic [WW-1:0]        base_r;
  logic [WW-1:0]        step_r;
  logic [WW-1:0]        idx_r;
  logic                 walk_done_r;

  // Remainder unit registers.
  logic [ROOT_W-1:0]    div_r;
  logic [NW-1:0]        rem_r;
  logic [NW-1:0]        rootb_r;
  logic [MOD_CNT_W-1:0] mcnt_r;

  // Result registers.
  logic [RANK_W-1:0]    rank_a_r;
  logic [RANK_W-1:0]    rank_b_r;
  logic                 in_range_r;
  logic                 config_error_r;

  logic [CW-1:0]     nc_ext;
  logic [CW-1:0]     max_ext;
  logic [NW-1:0]     n_eff;
  logic [PATH_W-1:0] path_c;
  logic [WW-1:0]     n_plus;
  logic [WW-1:0]     last_cnt;
  logic [WW-1:0]     left_size;
  logic              go_right;
  logic [WW-1:0]     trial;
  logic [WW-1:0]     n_w;
  logic [WW-1:0]     sum_b;
  logic [WW-1:0]     sum_ra;
  logic [WW-1:0]     sum_rb;
  logic [WW-1:0]     ra;
  logic [WW-1:0]     rb;

  assign sts.walk_done = walk_done_r;
  assign sts.mod_done  = (mcnt_r == MOD_DONE);
  assign rank_a        = rank_a_r;
  assign rank_b        = rank_b_r;
  assign in_range      = in_range_r;
  assign config_error  = config_error_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      root_a_r     <= ROOT_A_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NODE_COUNT: node_count_r <= cfg_data;
        REG_ROOT_A:     root_a_r     <= cfg_data[ROOT_W-1:0];
        default: ;
      endcase
    end
  end

  // Node count saturated to the largest supported tree.
  always_comb begin
    nc_ext  = CW'(node_count_r);
    max_ext = CW'(MAX_NODES);
    n_eff   = (nc_ext > max_ext) ? NW'(max_ext) : NW'(nc_ext);
  end

  // Size of the current node's left subtree: full levels plus its share of the last level.
  always_comb begin
    path_c = PATH_W'(pos_r) + PATH_W'(1);
    n_plus = WW'(n_r) + WW'(1);
    last_cnt = (n_plus > base_r) ? (n_plus - base_r) : '0;
    if (last_cnt > step_r) begin
      last_cnt = step_r;
    end
    left_size = (step_r == '0) ? '0 : (step_r - WW'(1) + last_cnt);
    go_right  = |(path_r & bitsel_r);
  end

  // Remainder step and result arithmetic.
  always_comb begin
    n_w    = WW'(n_r);
    trial  = {rem_r, div_r[ROOT_W-1]};
    sum_b  = WW'(rem_r) + WW'(n_r >> 1);
    sum_ra = idx_r + WW'(rem_r);
    sum_rb = idx_r + WW'(rootb_r);
    ra     = (sum_ra >= n_w) ? (sum_ra - n_w) : sum_ra;
    rb     = (sum_rb >= n_w) ? (sum_rb - n_w) : sum_rb;
  end

  // Request capture and setup of both units.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_r  <= position;
      n_r    <= n_eff;
      root_r <= root_a_r;
    end
    if (cmd.setup) begin
      inr_r    <= (n_r != '0) && (32'(pos_r) < 32'(n_r));
      err_r    <= (32'(root_r) >= 32'(n_r));
      path_r   <= path_c;
      bitsel_r <= (PATH_W'(1) << msb_idx(32'(path_c))) >> 1;
      base_r   <= WW'(1) << msb_idx(32'(n_r));
      step_r   <= (WW'(1) << msb_idx(32'(n_r))) >> 1;
      idx_r    <= '0;
      div_r    <= root_r;
      rem_r    <= '0;
    end else if (cmd.step) begin
      // One tree level per cycle, from the root down to the position.
      if (bitsel_r != '0) begin
        if (go_right) begin
          idx_r  <= idx_r + left_size + WW'(1);
          base_r <= base_r + step_r;
        end
        step_r   <= step_r >> 1;
        bitsel_r <= bitsel_r >> 1;
      end else if (!walk_done_r) begin
        idx_r <= idx_r + left_size;
      end
      // Restoring remainder of root_a by the node count, one bit per cycle.
      if (mcnt_r < MOD_LAST_DIV) begin
        rem_r <= (trial >= n_w) ? NW'(trial - n_w) : NW'(trial);
        div_r <= div_r << 1;
      end else if (mcnt_r == MOD_LAST_DIV) begin
        rootb_r <= (sum_b >= n_w) ? NW'(sum_b - n_w) : NW'(sum_b);
      end
    end
  end

  // Control flags of the two units; a new request clears them as soon as it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_done_r <= 1'b0;
      mcnt_r      <= '0;
    end else if (cmd.load || cmd.setup) begin
      walk_done_r <= 1'b0;
      mcnt_r      <= '0;
    end else if (cmd.step) begin
      if (bitsel_r == '0) begin
        walk_done_r <= 1'b1;
      end
      if (mcnt_r != MOD_DONE) begin
        mcnt_r <= mcnt_r + MOD_CNT_W'(1);
      end
    end
  end

  // Result registers; ranks read as zero for a position outside the tree.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rank_a_r       <= inr_r ? RANK_W'(ra) : '0;
      rank_b_r       <= inr_r ? RANK_W'(rb) : '0;
      in_range_r     <= inr_r;
      config_error_r <= err_r;
    end
  end

  // The remainders stay below the node count once the unit is done.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mod_done |-> (rem_r < n_r) || (n_r == '0))
    else $error("root_a remainder not reduced below node count");

  a_rootb_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.mod_done |-> (rootb_r < n_r) || (n_r == '0))
    else $error("tree B root not reduced below node count");

  // Setup restarts both units.
  a_setup_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.setup |=> !sts.walk_done && !sts.mod_done)
    else $error("units not restarted by setup");

endmodule

// ===== hw/rtl/double_tree_inorder_rank_map.sv =====
// Top level of the double binary tree in-order rank map.
//
// One request on in_ch carries a heap position (root 0, children 2p+1 and
// 2p+2). The result on out_ch gives the rank held at that position in tree A
// and in tree B, where ranks follow each tree's in-order walk, tree A is
// offset by root_a and tree B by root_a plus half the node count.
// in_range is low and both ranks are zero for a position at or beyond the
// node count; config_error is high when root_a is not below the node count.
// Both channels use valid/ready; a request moves when both are high.
// cfg_we writes cfg_data into register cfg_idx (0 node_count, 1 root_a);
// other indexes are ignored. Write only while no request is in flight.
// The result is loaded once the remainder of root_a, taken one bit per step
// over its 10 bits plus one step for tree B's root, and the level walk,
// which runs beside it from the root down to the position, have both finished.
// One request is worked on at a time; the next is taken in the cycle after
// the result is loaded.
// If the receiver stalls, the result waits in the output register while the
// next request is worked on; that one then waits until the register frees.
// Reset returns node_count to 8, root_a to 0 and empties the block.
module double_tree_inorder_rank_map #(
  parameter int MAX_NODES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dtrm_in_if.sink                        in_ch,
  dtrm_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [dtrm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [dtrm_pkg::CFG_W-1:0]     cfg_data
);
  import dtrm_pkg::*;

  dtrm_cmd_t cmd;
  dtrm_sts_t sts;

  // Sequencing.
  dtrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic and storage.
  dtrm_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .position     (in_ch.position),
    .cmd          (cmd),
    .sts          (sts),
    .rank_a       (out_ch.rank_a),
    .rank_b       (out_ch.rank_b),
    .in_range     (out_ch.in_range),
    .config_error (out_ch.config_error)
  );

endmodule
